### hdl/vbfe_pkg.sv
// Shared types, constants and the face corner table of the voxel boundary face emitter.
package vbfe_pkg;

  // Field widths
  localparam int CX_W   = 7;
  localparam int CY_W   = 7;
  localparam int CZ_W   = 6;
  localparam int DXY_W  = 8;
  localparam int DZ_W   = 7;
  localparam int VIDX_W = 21;
  localparam int W_W    = 9;   // nx + 1
  localparam int P_W    = 17;  // (nx + 1) * (ny + 1)
  localparam int NFACE  = 6;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_X_DIV = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_DIV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_DIV = 2'd2;

  localparam logic [DXY_W-1:0] X_DIV_RST = 8'd128;
  localparam logic [DXY_W-1:0] Y_DIV_RST = 8'd128;
  localparam logic [DZ_W-1:0]  Z_DIV_RST = 7'd64;

  localparam int DEF_MAX_X_CELLS = 128;
  localparam int DEF_MAX_Y_CELLS = 128;
  localparam int DEF_MAX_Z_CELLS = 64;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Work queue between front and back
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [CX_W-1:0]  x;
    logic [CY_W-1:0]  y;
    logic [CZ_W-1:0]  z;
    logic [NFACE-1:0] mask;  // exposed faces: +z, -z, +y, -y, +x, -x
  } entry_t;

  // Corner codes per face: bit0 = +1 in x, bit1 = +1 in y, bit2 = +1 in z
  localparam logic [2:0] FACE_CORNERS [0:5][0:5] = '{
    '{3'd5, 3'd4, 3'd6, 3'd5, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd3, 3'd0, 3'd3, 3'd2},
    '{3'd2, 3'd3, 3'd7, 3'd2, 3'd7, 3'd6},
    '{3'd0, 3'd5, 3'd1, 3'd0, 3'd4, 3'd5},
    '{3'd1, 3'd5, 3'd7, 3'd1, 3'd7, 3'd3},
    '{3'd4, 3'd0, 3'd2, 3'd4, 3'd2, 3'd6}
  };

endpackage

### hdl/vbfe_front.sv
// Front end: occupancy store, load writes and neighbor reads that classify a queried cell.
module vbfe_front #(
  parameter int MAX_X_CELLS = vbfe_pkg::DEF_MAX_X_CELLS,
  parameter int MAX_Y_CELLS = vbfe_pkg::DEF_MAX_Y_CELLS,
  parameter int MAX_Z_CELLS = vbfe_pkg::DEF_MAX_Z_CELLS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic [vbfe_pkg::CX_W-1:0]  cell_x_i,
  input  logic [vbfe_pkg::CY_W-1:0]  cell_y_i,
  input  logic [vbfe_pkg::CZ_W-1:0]  cell_z_i,
  input  logic                       filled_bit_i,
  input  logic [vbfe_pkg::DXY_W-1:0] nx_i,
  input  logic [vbfe_pkg::DXY_W-1:0] ny_i,
  input  logic [vbfe_pkg::DZ_W-1:0]  nz_i,
  output logic                       push_o,
  output vbfe_pkg::entry_t           entry_o,
  input  logic                       full_i
);

  localparam int CELLS = MAX_X_CELLS * MAX_Y_CELLS * MAX_Z_CELLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int YSTEP = MAX_X_CELLS;
  localparam int ZSTEP = MAX_X_CELLS * MAX_Y_CELLS;

  typedef enum logic [1:0] {F_IDLE, F_READ, F_DONE} fst_e;

  fst_e st_q;
  logic [2:0] s_q;

  logic [vbfe_pkg::CX_W-1:0]  x_q;
  logic [vbfe_pkg::CY_W-1:0]  y_q;
  logic [vbfe_pkg::CZ_W-1:0]  z_q;
  logic [AW-1:0]              ca_q;
  logic [vbfe_pkg::NFACE-1:0] bnd_q;
  logic [6:0]                 bits_q;  // center, then neighbors in face order
  logic                       rd_q;

  logic                       mem [CELLS];

  logic                       acc;
  logic                       in_grid;
  logic [AW-1:0]              ca_in;
  logic [vbfe_pkg::NFACE-1:0] bnd_in;
  logic [vbfe_pkg::NFACE-1:0] exposed;
  logic                       need;
  logic                       wr_en;
  logic                       rd_en;
  logic [7:0]                 ins;
  logic [AW-1:0]              raddr;

  always_comb begin
    in_grid = (vbfe_pkg::DXY_W'(cell_x_i) < nx_i) && (vbfe_pkg::DXY_W'(cell_y_i) < ny_i) &&
              (vbfe_pkg::DZ_W'(cell_z_i) < nz_i);
    ca_in   = AW'(cell_z_i) * AW'(ZSTEP) + AW'(cell_y_i) * AW'(YSTEP) + AW'(cell_x_i);
    bnd_in[0] = (vbfe_pkg::DZ_W'(cell_z_i) + 7'd1) >= nz_i;
    bnd_in[1] = cell_z_i == '0;
    bnd_in[2] = (vbfe_pkg::DXY_W'(cell_y_i) + 8'd1) >= ny_i;
    bnd_in[3] = cell_y_i == '0;
    bnd_in[4] = (vbfe_pkg::DXY_W'(cell_x_i) + 8'd1) >= nx_i;
    bnd_in[5] = cell_x_i == '0;

    exposed    = bnd_q | ~bits_q[6:1];
    need       = bits_q[0] && (exposed != '0);
    push_o     = (st_q == F_DONE) && need && !full_i;
    in_ready_o = (st_q == F_IDLE) || ((st_q == F_DONE) && (!need || !full_i));
    acc        = in_valid_i && in_ready_o;
    wr_en      = acc && (op_i == vbfe_pkg::OP_LOAD) && in_grid;

    // skip reads of neighbors outside the grid
    ins   = {1'b0, ~bnd_q, 1'b1};
    rd_en = (st_q == F_READ) && ins[s_q];

    case (s_q)
      3'd0:    raddr = ca_q;
      3'd1:    raddr = ca_q + AW'(ZSTEP);
      3'd2:    raddr = ca_q - AW'(ZSTEP);
      3'd3:    raddr = ca_q + AW'(YSTEP);
      3'd4:    raddr = ca_q - AW'(YSTEP);
      3'd5:    raddr = ca_q + AW'(1);
      3'd6:    raddr = ca_q - AW'(1);
      default: raddr = ca_q;
    endcase

    entry_o.x    = x_q;
    entry_o.y    = y_q;
    entry_o.z    = z_q;
    entry_o.mask = exposed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
      s_q  <= '0;
    end else if (acc && (op_i == vbfe_pkg::OP_QUERY) && in_grid) begin
      st_q <= F_READ;
      s_q  <= '0;
    end else begin
      case (st_q)
        F_READ: begin
          s_q <= s_q + 3'd1;
          if (s_q == 3'd7) st_q <= F_DONE;
        end
        F_DONE: begin
          if (in_ready_o) st_q <= F_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      x_q   <= cell_x_i;
      y_q   <= cell_y_i;
      z_q   <= cell_z_i;
      ca_q  <= ca_in;
      bnd_q <= bnd_in;
    end
    // read data is registered and arrives in the cycle after its address
    if ((st_q == F_READ) && (s_q != 3'd0)) bits_q[s_q - 3'd1] <= rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[ca_in] <= filled_bit_i;
    if (rd_en) rd_q <= mem[raddr];
  end

`ifndef ASSERT_OFF
  a_no_accept_while_reading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == F_READ) |-> !in_ready_o)
    else $error("front takes a transaction while neighbor reads are in flight");

  a_done_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == F_READ) && (s_q == 3'd7)) |=> (st_q == F_DONE))
    else $error("front skipped classification after the last read");
`endif

endmodule

### hdl/vbfe_queue.sv
// Short queue of classified cells between front and back.
module vbfe_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vbfe_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output vbfe_pkg::entry_t entry_o,
  output logic             empty_o
);

  localparam int PW = (vbfe_pkg::QDEPTH > 1) ? $clog2(vbfe_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(vbfe_pkg::QDEPTH + 1);

  vbfe_pkg::entry_t slots_q [vbfe_pkg::QDEPTH];
  logic [PW-1:0] wp_q;
  logic [PW-1:0] rp_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = cnt_q == CW'(vbfe_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign entry_o = slots_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(vbfe_pkg::QDEPTH - 1)) ? '0 : wp_q + PW'(1);
      if (pop_i)  rp_q <= (rp_q == PW'(vbfe_pkg::QDEPTH - 1)) ? '0 : rp_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wp_q] <= entry_i;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from an empty queue");
`endif

endmodule

### hdl/vbfe_back.sv
// Back end: turns a classified cell into vertex indices, registered, one per cycle while ready.
module vbfe_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  vbfe_pkg::entry_t            entry_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  input  logic [vbfe_pkg::W_W-1:0]    row_w_i,
  input  logic [vbfe_pkg::P_W-1:0]    plane_p_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [vbfe_pkg::VIDX_W-1:0] vertex_index_o,
  output logic                        last_o
);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_ADD, B_EMIT} bst_e;

  bst_e st_q;
  logic [vbfe_pkg::NFACE-1:0] rem_q;
  logic [2:0]                 k_q;
  logic                       ovalid_q;

  logic [vbfe_pkg::CX_W-1:0]   x_q;
  logic [vbfe_pkg::CY_W-1:0]   y_q;
  logic [vbfe_pkg::CZ_W-1:0]   z_q;
  logic [vbfe_pkg::VIDX_W-1:0] zp_q;
  logic [15:0]                 yw_q;
  logic [vbfe_pkg::VIDX_W-1:0] base_q;
  logic [vbfe_pkg::VIDX_W-1:0] vidx_q;
  logic                        last_q;

  logic [22:0]                 zp_full;
  logic [15:0]                 yw_full;
  logic [2:0]                  face;
  logic [vbfe_pkg::NFACE-1:0]  fbit;
  logic [2:0]                  corner;
  logic [vbfe_pkg::VIDX_W-1:0] idx;
  logic                        last_c;
  logic                        ld;

  always_comb begin
    pop_o   = (st_q == B_IDLE) && !empty_i;
    zp_full = 23'(z_q) * 23'(plane_p_i);
    yw_full = 16'(y_q) * 16'(row_w_i);

    // lowest remaining face goes first
    face = 3'd0;
    for (int i = vbfe_pkg::NFACE - 1; i >= 0; i--) begin
      if (rem_q[i]) face = 3'(i);
    end
    fbit   = vbfe_pkg::NFACE'(1) << face;
    corner = vbfe_pkg::FACE_CORNERS[face][k_q];
    idx    = base_q
           + (corner[2] ? vbfe_pkg::VIDX_W'(plane_p_i) : '0)
           + (corner[1] ? vbfe_pkg::VIDX_W'(row_w_i) : '0)
           + vbfe_pkg::VIDX_W'(corner[0]);
    last_c = (k_q == 3'd5) && (rem_q == fbit);
    ld     = (st_q == B_EMIT) && (!ovalid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_IDLE;
      rem_q    <= '0;
      k_q      <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (ld) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      case (st_q)
        B_IDLE: begin
          if (!empty_i) begin
            rem_q <= entry_i.mask;
            k_q   <= '0;
            st_q  <= B_MUL;
          end
        end
        B_MUL: st_q <= B_ADD;
        B_ADD: st_q <= B_EMIT;
        B_EMIT: begin
          if (ld) begin
            if (k_q == 3'd5) begin
              k_q   <= '0;
              rem_q <= rem_q & ~fbit;
              if (last_c) st_q <= B_IDLE;
            end else begin
              k_q <= k_q + 3'd1;
            end
          end
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      x_q <= entry_i.x;
      y_q <= entry_i.y;
      z_q <= entry_i.z;
    end
    if (st_q == B_MUL) begin
      zp_q <= zp_full[vbfe_pkg::VIDX_W-1:0];
      yw_q <= yw_full;
    end
    if (st_q == B_ADD) begin
      base_q <= zp_q + vbfe_pkg::VIDX_W'(yw_q) + vbfe_pkg::VIDX_W'(x_q);
    end
    if (ld) begin
      vidx_q <= idx;
      last_q <= last_c;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign vertex_index_o = vidx_q;
  assign last_o         = last_q;

`ifndef ASSERT_OFF
  a_emit_has_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == B_EMIT) |-> (rem_q != '0))
    else $error("emitting with no exposed face left");

  a_last_ends_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld && last_c) |=> (st_q == B_IDLE) && (k_q == 3'd0))
    else $error("back kept emitting after the final index of a cell");
`endif

endmodule

### hdl/voxel_boundary_face_emitter.sv
// Top level of the voxel boundary face emitter: configuration registers and the front/queue/back.
//
// Input channel (in_valid_i/in_ready_o): a load transaction writes one cell's occupancy bit
// and gives no result; a query transaction names a cell and, when it is filled, yields six
// vertex indices for each exposed face, in face order +z, -z, +y, -y, +x, -x, with last_o
// set on the final index of the cell. Cells at or beyond the clamped divisions are dropped.
// Loads are taken one per cycle while no query holds the input side. A query holds the input
// side until its neighbor reads are done and the queue has room: the single-port occupancy
// memory is read once for the cell and once for each neighbor inside the grid. Output channel
// (out_valid_o/out_ready_i): one index per cycle from an output register while the receiver is
// ready; the back end emits 6 to 36 indices per cell after the address setup of each cell.
// A two-entry queue parts front and back, so the front keeps taking transactions while the
// receiver stalls, until the queue fills. Configuration writes (cfg_we_i) are registered; the
// user must make them only while the block is idle, which the block does not enforce.
// Reset clears the control state and sets the divisions to 128 x 128 x 64. The occupancy
// memory is not cleared: every cell that a query touches must be loaded first.
module voxel_boundary_face_emitter #(
  parameter int MAX_X_CELLS = vbfe_pkg::DEF_MAX_X_CELLS,
  parameter int MAX_Y_CELLS = vbfe_pkg::DEF_MAX_Y_CELLS,
  parameter int MAX_Z_CELLS = vbfe_pkg::DEF_MAX_Z_CELLS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vbfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vbfe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [vbfe_pkg::CX_W-1:0]       cell_x_i,
  input  logic [vbfe_pkg::CY_W-1:0]       cell_y_i,
  input  logic [vbfe_pkg::CZ_W-1:0]       cell_z_i,
  input  logic                            filled_bit_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [vbfe_pkg::VIDX_W-1:0]     vertex_index_o,
  output logic                            last_o
);

  logic [vbfe_pkg::DXY_W-1:0] xdiv_q;
  logic [vbfe_pkg::DXY_W-1:0] ydiv_q;
  logic [vbfe_pkg::DZ_W-1:0]  zdiv_q;
  logic [vbfe_pkg::P_W-1:0]   plane_q;

  logic [vbfe_pkg::DXY_W-1:0] nx;
  logic [vbfe_pkg::DXY_W-1:0] ny;
  logic [vbfe_pkg::DZ_W-1:0]  nz;
  logic [vbfe_pkg::W_W-1:0]   row_w;
  logic [vbfe_pkg::W_W-1:0]   col_h;

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  vbfe_pkg::entry_t push_entry;
  vbfe_pkg::entry_t head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xdiv_q <= vbfe_pkg::X_DIV_RST;
      ydiv_q <= vbfe_pkg::Y_DIV_RST;
      zdiv_q <= vbfe_pkg::Z_DIV_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vbfe_pkg::CFG_X_DIV: xdiv_q <= cfg_data_i;
        vbfe_pkg::CFG_Y_DIV: ydiv_q <= cfg_data_i;
        vbfe_pkg::CFG_Z_DIV: zdiv_q <= cfg_data_i[vbfe_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // zero means one cell; clamp to the grid the store holds
  always_comb begin
    if (xdiv_q == '0) nx = vbfe_pkg::DXY_W'(1);
    else if (11'(xdiv_q) > 11'(MAX_X_CELLS)) nx = vbfe_pkg::DXY_W'(MAX_X_CELLS);
    else nx = xdiv_q;
    if (ydiv_q == '0) ny = vbfe_pkg::DXY_W'(1);
    else if (11'(ydiv_q) > 11'(MAX_Y_CELLS)) ny = vbfe_pkg::DXY_W'(MAX_Y_CELLS);
    else ny = ydiv_q;
    if (zdiv_q == '0) nz = vbfe_pkg::DZ_W'(1);
    else if (11'(zdiv_q) > 11'(MAX_Z_CELLS)) nz = vbfe_pkg::DZ_W'(MAX_Z_CELLS);
    else nz = zdiv_q;
    row_w = vbfe_pkg::W_W'(nx) + vbfe_pkg::W_W'(1);
    col_h = vbfe_pkg::W_W'(ny) + vbfe_pkg::W_W'(1);
  end

  // vertex plane size, settled long before a query reaches the back end
  always_ff @(posedge clk_i) begin
    plane_q <= vbfe_pkg::P_W'(row_w) * vbfe_pkg::P_W'(col_h);
  end

  vbfe_front #(
    .MAX_X_CELLS(MAX_X_CELLS),
    .MAX_Y_CELLS(MAX_Y_CELLS),
    .MAX_Z_CELLS(MAX_Z_CELLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .cell_z_i    (cell_z_i),
    .filled_bit_i(filled_bit_i),
    .nx_i        (nx),
    .ny_i        (ny),
    .nz_i        (nz),
    .push_o      (push),
    .entry_o     (push_entry),
    .full_i      (full)
  );

  vbfe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .entry_o(head_entry),
    .empty_o(empty)
  );

  vbfe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_i       (head_entry),
    .empty_i       (empty),
    .pop_o         (pop),
    .row_w_i       (row_w),
    .plane_p_i     (plane_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .vertex_index_o(vertex_index_o),
    .last_o        (last_o)
  );

endmodule

### tb/voxel_boundary_face_emitter_tb.sv
// Self-checking testbench for the voxel boundary face emitter: directed table, random phases.
`timescale 1ns / 1ps

module voxel_boundary_face_emitter_tb;

  localparam int GRID_X = vbfe_pkg::DEF_MAX_X_CELLS;
  localparam int GRID_Y = vbfe_pkg::DEF_MAX_Y_CELLS;
  localparam int GRID_Z = vbfe_pkg::DEF_MAX_Z_CELLS;
  localparam logic [vbfe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PRINT_LIMIT   = 40;

  // Corner codes per face, bit0 steps x, bit1 steps y, bit2 steps z
  localparam logic [2:0] FACE_CORNER [6][6] = '{
    '{3'd5, 3'd4, 3'd6, 3'd5, 3'd6, 3'd7},
    '{3'd0, 3'd1, 3'd3, 3'd0, 3'd3, 3'd2},
    '{3'd2, 3'd3, 3'd7, 3'd2, 3'd7, 3'd6},
    '{3'd0, 3'd5, 3'd1, 3'd0, 3'd4, 3'd5},
    '{3'd1, 3'd5, 3'd7, 3'd1, 3'd7, 3'd3},
    '{3'd4, 3'd0, 3'd2, 3'd4, 3'd2, 3'd6}
  };
  localparam int FACE_DX [6] = '{0, 0, 0, 0, 1, -1};
  localparam int FACE_DY [6] = '{0, 0, 1, -1, 0, 0};
  localparam int FACE_DZ [6] = '{1, -1, 0, 0, 0, 0};

  typedef struct packed {
    logic [vbfe_pkg::VIDX_W-1:0] vidx;
    logic                        last;
  } vertex_t;

  typedef struct packed {
    logic                      op;
    logic [vbfe_pkg::CX_W-1:0] x;
    logic [vbfe_pkg::CY_W-1:0] y;
    logic [vbfe_pkg::CZ_W-1:0] z;
    logic                      fill;
    logic                      no_faces;  // typed expectation: the transaction yields nothing
  } probe_t;

  localparam probe_t DIRECTED [24] = '{
    // isolated cell at the origin, then one face hidden
    '{vbfe_pkg::OP_LOAD,  7'd0,   7'd0,   6'd0,  1'b1, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd1,   7'd0,   6'd0,  1'b0, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd0,   7'd1,   6'd0,  1'b0, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd0,   7'd0,   6'd1,  1'b0, 1'b1},
    '{vbfe_pkg::OP_QUERY, 7'd0,   7'd0,   6'd0,  1'b0, 1'b0},
    '{vbfe_pkg::OP_LOAD,  7'd1,   7'd0,   6'd0,  1'b1, 1'b1},
    '{vbfe_pkg::OP_QUERY, 7'd0,   7'd0,   6'd0,  1'b0, 1'b0},
    // far corner of the full grid
    '{vbfe_pkg::OP_LOAD,  7'd127, 7'd127, 6'd63, 1'b1, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd126, 7'd127, 6'd63, 1'b1, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd127, 7'd126, 6'd63, 1'b0, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd127, 7'd127, 6'd62, 1'b1, 1'b1},
    '{vbfe_pkg::OP_QUERY, 7'd127, 7'd127, 6'd63, 1'b1, 1'b0},
    // empty cell: filled bit on a query is ignored
    '{vbfe_pkg::OP_LOAD,  7'd0,   7'd2,   6'd0,  1'b0, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd1,   7'd1,   6'd0,  1'b0, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd0,   7'd1,   6'd1,  1'b0, 1'b1},
    '{vbfe_pkg::OP_QUERY, 7'd0,   7'd1,   6'd0,  1'b1, 1'b1},
    // fully enclosed cell
    '{vbfe_pkg::OP_LOAD,  7'd5,   7'd5,   6'd5,  1'b1, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd5,   7'd5,   6'd6,  1'b1, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd5,   7'd5,   6'd4,  1'b1, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd5,   7'd6,   6'd5,  1'b1, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd5,   7'd4,   6'd5,  1'b1, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd6,   7'd5,   6'd5,  1'b1, 1'b1},
    '{vbfe_pkg::OP_LOAD,  7'd4,   7'd5,   6'd5,  1'b1, 1'b1},
    '{vbfe_pkg::OP_QUERY, 7'd5,   7'd5,   6'd5,  1'b0, 1'b1}
  };

  logic                            clk_i        = 1'b0;
  logic                            rst_ni       = 1'b0;
  logic                            cfg_we_i     = 1'b0;
  logic [vbfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [vbfe_pkg::CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                            in_valid_i   = 1'b0;
  logic                            in_ready_o;
  logic                            op_i         = vbfe_pkg::OP_LOAD;
  logic [vbfe_pkg::CX_W-1:0]       cell_x_i     = '0;
  logic [vbfe_pkg::CY_W-1:0]       cell_y_i     = '0;
  logic [vbfe_pkg::CZ_W-1:0]       cell_z_i     = '0;
  logic                            filled_bit_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i  = 1'b0;
  logic [vbfe_pkg::VIDX_W-1:0]     vertex_index_o;
  logic                            last_o;

  vertex_t                    pending_indices [$];
  bit                         occupancy_bit [int];
  logic [vbfe_pkg::DXY_W-1:0] x_div_reg = vbfe_pkg::X_DIV_RST;
  logic [vbfe_pkg::DXY_W-1:0] y_div_reg = vbfe_pkg::Y_DIV_RST;
  logic [vbfe_pkg::DZ_W-1:0]  z_div_reg = vbfe_pkg::Z_DIV_RST;

  int tx_idle_pct     = 0;
  int rx_stall_pct    = 0;
  bit long_hold_req   = 1'b0;
  int hold_left       = 0;
  int error_count     = 0;
  int items_done      = 0;
  int face_queries    = 0;
  int indices_checked = 0;

  voxel_boundary_face_emitter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .cell_z_i       (cell_z_i),
    .filled_bit_i   (filled_bit_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .vertex_index_o (vertex_index_o),
    .last_o         (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int cells_in_use(input int raw, input int limit);
    if (raw == 0) return 1;
    return (raw > limit) ? limit : raw;
  endfunction

  function automatic int span_x();
    return cells_in_use(int'(x_div_reg), GRID_X);
  endfunction

  function automatic int span_y();
    return cells_in_use(int'(y_div_reg), GRID_Y);
  endfunction

  function automatic int span_z();
    return cells_in_use(int'(z_div_reg), GRID_Z);
  endfunction

  function automatic bit in_grid(input int x, input int y, input int z);
    return x >= 0 && y >= 0 && z >= 0 && x < span_x() && y < span_y() && z < span_z();
  endfunction

  // Stored bits are addressed by absolute coordinates, independent of the divisions
  function automatic int cell_key(input int x, input int y, input int z);
    return (z * GRID_Y + y) * GRID_X + x;
  endfunction

  function automatic bit is_filled(input int x, input int y, input int z);
    int key;
    key = cell_key(x, y, z);
    return occupancy_bit.exists(key) && occupancy_bit[key];
  endfunction

  function automatic bit neighborhood_known(input int x, input int y, input int z);
    if (!occupancy_bit.exists(cell_key(x, y, z))) return 1'b0;
    for (int f = 0; f < vbfe_pkg::NFACE; f++) begin
      if (in_grid(x + FACE_DX[f], y + FACE_DY[f], z + FACE_DZ[f]) &&
          !occupancy_bit.exists(cell_key(x + FACE_DX[f], y + FACE_DY[f], z + FACE_DZ[f])))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int pick_coord(input int n);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return n - 1;
      default: return $urandom_range(0, n - 1);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < PRINT_LIMIT)
      $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
    error_count++;
  endtask

  // Update the occupancy store and queue the vertex indices one transaction yields
  task automatic predict_face_indices(input logic op, input int x, input int y, input int z,
                                      input logic fill, input bit emit);
    int      nx, ny, cnt, vx, vy, vz, tail;
    vertex_t v;
    nx = span_x();
    ny = span_y();
    cnt = 0;
    if (!in_grid(x, y, z)) return;
    if (op == vbfe_pkg::OP_LOAD) begin
      occupancy_bit[cell_key(x, y, z)] = fill;
      return;
    end
    if (!emit || !is_filled(x, y, z)) return;
    for (int f = 0; f < vbfe_pkg::NFACE; f++) begin
      if (in_grid(x + FACE_DX[f], y + FACE_DY[f], z + FACE_DZ[f]) &&
          is_filled(x + FACE_DX[f], y + FACE_DY[f], z + FACE_DZ[f]))
        continue;
      for (int k = 0; k < 6; k++) begin
        vx = x + int'(FACE_CORNER[f][k][0]);
        vy = y + int'(FACE_CORNER[f][k][1]);
        vz = z + int'(FACE_CORNER[f][k][2]);
        v.vidx = vbfe_pkg::VIDX_W'(vz * (ny + 1) * (nx + 1) + vy * (nx + 1) + vx);
        v.last = 1'b0;
        pending_indices.insert(pending_indices.size(), v);
        cnt++;
      end
    end
    if (cnt > 0) begin
      tail = pending_indices.size() - 1;
      v = pending_indices[tail];
      v.last = 1'b1;
      pending_indices[tail] = v;
      face_queries++;
    end
  endtask

  // Present one transaction at the falling edge and hold it until accepted
  task automatic offer_item(input logic op, input int x, input int y, input int z,
                            input logic fill, input bit no_faces);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    op_i         = op;
    cell_x_i     = x[vbfe_pkg::CX_W-1:0];
    cell_y_i     = y[vbfe_pkg::CY_W-1:0];
    cell_z_i     = z[vbfe_pkg::CZ_W-1:0];
    filled_bit_i = fill;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (in_grid(x, y, z)) items_done++;
    predict_face_indices(op, x, y, z, fill, !no_faces);
    @(negedge clk_i);
  endtask

  // Load the cell and its in-grid neighbors where unknown (or at random), then query it
  task automatic cluster_query();
    int x, y, z, ax, ay, az;
    x = pick_coord(span_x());
    y = pick_coord(span_y());
    z = pick_coord(span_z());
    if ($urandom_range(0, 2) == 0 || !occupancy_bit.exists(cell_key(x, y, z)))
      offer_item(vbfe_pkg::OP_LOAD, x, y, z, $urandom_range(0, 9) != 0, 1'b0);
    for (int f = 0; f < vbfe_pkg::NFACE; f++) begin
      ax = x + FACE_DX[f];
      ay = y + FACE_DY[f];
      az = z + FACE_DZ[f];
      if (in_grid(ax, ay, az) &&
          ($urandom_range(0, 2) == 0 || !occupancy_bit.exists(cell_key(ax, ay, az))))
        offer_item(vbfe_pkg::OP_LOAD, ax, ay, az, $urandom_range(0, 1) != 0, 1'b0);
    end
    offer_item(vbfe_pkg::OP_QUERY, x, y, z, $urandom_range(0, 1) != 0, 1'b0);
  endtask

  // Random transaction anywhere in the field range; a query that would touch
  // never-loaded cells becomes a load
  task automatic stray_item();
    int   x, y, z;
    logic op;
    x  = $urandom_range(0, (1 << vbfe_pkg::CX_W) - 1);
    y  = $urandom_range(0, (1 << vbfe_pkg::CY_W) - 1);
    z  = $urandom_range(0, (1 << vbfe_pkg::CZ_W) - 1);
    op = ($urandom_range(0, 1) != 0) ? vbfe_pkg::OP_QUERY : vbfe_pkg::OP_LOAD;
    if (op == vbfe_pkg::OP_QUERY && in_grid(x, y, z) && !neighborhood_known(x, y, z))
      op = vbfe_pkg::OP_LOAD;
    offer_item(op, x, y, z, $urandom_range(0, 1) != 0, 1'b0);
  endtask

  task automatic write_divisions(input logic [vbfe_pkg::CFG_DATA_W-1:0] xd,
                                 input logic [vbfe_pkg::CFG_DATA_W-1:0] yd,
                                 input logic [vbfe_pkg::CFG_DATA_W-1:0] zd,
                                 input bit with_spare);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = vbfe_pkg::CFG_X_DIV;
    cfg_data_i = xd;
    @(negedge clk_i);
    cfg_idx_i  = vbfe_pkg::CFG_Y_DIV;
    cfg_data_i = yd;
    @(negedge clk_i);
    cfg_idx_i  = vbfe_pkg::CFG_Z_DIV;
    cfg_data_i = zd;
    @(negedge clk_i);
    if (with_spare) begin
      cfg_idx_i  = CFG_SPARE;
      cfg_data_i = vbfe_pkg::CFG_DATA_W'($urandom);
      @(negedge clk_i);
    end
    cfg_we_i  = 1'b0;
    x_div_reg = xd;
    y_div_reg = yd;
    z_div_reg = zd[vbfe_pkg::DZ_W-1:0];
  endtask

  // Drop valid, wait for every queued index, then let trailing queries finish
  task automatic wait_idle();
    in_valid_i = 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && pending_indices.size() != 0; n++) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (pending_indices.size() != 0) begin
      report_mismatch("indices never emitted", 0, pending_indices.size());
      pending_indices.delete();
    end
  endtask

  task automatic run_phase(input logic [vbfe_pkg::CFG_DATA_W-1:0] xd,
                           input logic [vbfe_pkg::CFG_DATA_W-1:0] yd,
                           input logic [vbfe_pkg::CFG_DATA_W-1:0] zd,
                           input int tx, input int rx, input bit with_spare);
    int target;
    write_divisions(xd, yd, zd, with_spare);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    target = items_done + PHASE_ITEMS;
    while (items_done < target) begin
      if ($urandom_range(0, 9) < 7) cluster_query();
      else stray_item();
    end
    wait_idle();
  endtask

  // Receiver: random stalls, or a long hold when requested
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left     = HOLD_CYCLES;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      indices_checked++;
      if (pending_indices.size() == 0) begin
        report_mismatch("index with no query pending", int'(vertex_index_o), 0);
      end else begin
        want = pending_indices.pop_front();
        if (vertex_index_o !== want.vidx)
          report_mismatch("vertex_index", int'(vertex_index_o), int'(want.vidx));
        if (last_o !== want.last) report_mismatch("last", int'(last_o), int'(want.last));
      end
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < $size(DIRECTED); i++)
      offer_item(DIRECTED[i].op, int'(DIRECTED[i].x), int'(DIRECTED[i].y), int'(DIRECTED[i].z),
                 DIRECTED[i].fill, DIRECTED[i].no_faces);
    wait_idle();

    run_phase(8'd128, 8'd128, 8'd64, 0, 0, 1'b0);
    run_phase(8'd3, 8'd2, 8'd4, 63, 0, 1'b1);
    run_phase(8'd0, 8'd255, 8'h80, 0, 63, 1'b0);
    run_phase(8'd200, 8'd1, 8'd127, 36, 36, 1'b0);

    // Hold the receiver off while queries keep coming, so the queue fills
    write_divisions(8'd5, 8'd6, 8'd3, 1'b0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(posedge clk_i);
    long_hold_req = 1'b1;
    @(negedge clk_i);
    repeat (12) cluster_query();
    wait_idle();

    $display("Covered %0d in-grid transactions, %0d queries with exposed faces, %0d indices.",
             items_done, face_queries, indices_checked);
    $display("Grids: full, small, one-cell and saturated divisions; idle, stall and long hold.");
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
